// ===== hw/rtl/escalating_double_beep_alert_top_defines.svh =====
// assertion macros for the escalating double-beep alert checker
// used by edba_checker only; expects clk and arst_n in scope
`ifndef ESCALATING_DOUBLE_BEEP_ALERT_TOP_DEFINES_SVH
`define ESCALATING_DOUBLE_BEEP_ALERT_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EDBA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edba checker: implication failed");

// next-cycle implication, disabled in reset
`define EDBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edba checker: next-cycle implication failed");

`endif

// ===== hw/rtl/edba_pkg.sv =====
// shared types, register indexes and reset values of the double-beep alert
// no dependencies
package edba_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_BEEP_LEN   = 3'd0;
	localparam cfg_idx_t REG_GAP_LEN    = 3'd1;
	localparam cfg_idx_t REG_FIRST_THR  = 3'd2;
	localparam cfg_idx_t REG_SECOND_THR = 3'd3;
	localparam cfg_idx_t REG_SLOW_INT   = 3'd4;
	localparam cfg_idx_t REG_MEDIUM_INT = 3'd5;
	localparam cfg_idx_t REG_FAST_INT   = 3'd6;

	localparam logic [15:0] BEEP_LEN_RST   = 16'd100;
	localparam logic [15:0] GAP_LEN_RST    = 16'd100;
	localparam logic [31:0] FIRST_THR_RST  = 32'd30000;
	localparam logic [31:0] SECOND_THR_RST = 32'd60000;
	localparam logic [15:0] SLOW_INT_RST   = 16'd10000;
	localparam logic [15:0] MEDIUM_INT_RST = 16'd5000;
	localparam logic [15:0] FAST_INT_RST   = 16'd2000;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BEEP1 = 4'b0010,
		PH_GAP   = 4'b0100,
		PH_BEEP2 = 4'b1000
	} phase_t;

	typedef logic [1:0] phase_code_t;
	localparam phase_code_t PHASE_CODE_IDLE  = 2'd0;
	localparam phase_code_t PHASE_CODE_BEEP1 = 2'd1;
	localparam phase_code_t PHASE_CODE_GAP   = 2'd2;
	localparam phase_code_t PHASE_CODE_BEEP2 = 2'd3;

	typedef struct packed {
		logic [15:0] beep_len;
		logic [15:0] gap_len;
		logic [31:0] first_thr;
		logic [31:0] second_thr;
		logic [15:0] slow_int;
		logic [15:0] medium_int;
		logic [15:0] fast_int;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] phase_start;
		logic [31:0] last_alert;
		logic        first_done;
		logic        buzzer;
	} seq_state_t;

	function automatic phase_code_t phase_code(phase_t p);
		case (p)
			PH_IDLE:  return PHASE_CODE_IDLE;
			PH_BEEP1: return PHASE_CODE_BEEP1;
			PH_GAP:   return PHASE_CODE_GAP;
			default:  return PHASE_CODE_BEEP2;
		endcase
	endfunction

endpackage

// ===== hw/rtl/edba_cfg.sv =====
// configuration register file of the double-beep alert
// depends on edba_pkg
module edba_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  edba_pkg::cfg_idx_t wr_index,
	input  logic [31:0]        wr_data,
	output edba_pkg::cfg_t     cfg
);
	import edba_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beep_len   <= BEEP_LEN_RST;
			cfg_q.gap_len    <= GAP_LEN_RST;
			cfg_q.first_thr  <= FIRST_THR_RST;
			cfg_q.second_thr <= SECOND_THR_RST;
			cfg_q.slow_int   <= SLOW_INT_RST;
			cfg_q.medium_int <= MEDIUM_INT_RST;
			cfg_q.fast_int   <= FAST_INT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BEEP_LEN:   cfg_q.beep_len   <= wr_data[15:0];
				REG_GAP_LEN:    cfg_q.gap_len    <= wr_data[15:0];
				REG_FIRST_THR:  cfg_q.first_thr  <= wr_data;
				REG_SECOND_THR: cfg_q.second_thr <= wr_data;
				REG_SLOW_INT:   cfg_q.slow_int   <= wr_data[15:0];
				REG_MEDIUM_INT: cfg_q.medium_int <= wr_data[15:0];
				REG_FAST_INT:   cfg_q.fast_int   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/edba_step.sv =====
// next-state logic of the double-beep sequencer for one evaluation
// depends on edba_pkg
module edba_step (
	input  edba_pkg::cfg_t       cfg,
	input  edba_pkg::seq_state_t cur,
	input  logic                 alarm_active,
	input  logic [31:0]          now_ms,
	input  logic [31:0]          alarm_age_ms,
	output edba_pkg::seq_state_t nxt
);
	import edba_pkg::*;

	logic [31:0] elapsed;
	logic [31:0] since_alert;
	logic [15:0] interval;

	assign elapsed     = now_ms - cur.phase_start;
	assign since_alert = now_ms - cur.last_alert;

	// first threshold tested first, whatever the order of the two
	always_comb begin
		if (alarm_age_ms < cfg.first_thr) begin
			interval = cfg.slow_int;
		end else if (alarm_age_ms < cfg.second_thr) begin
			interval = cfg.medium_int;
		end else begin
			interval = cfg.fast_int;
		end
	end

	always_comb begin
		nxt = cur;
		if (!alarm_active) begin
			nxt.buzzer     = 1'b0;
			nxt.phase      = PH_IDLE;
			nxt.last_alert = '0;
			nxt.first_done = 1'b0;
		end else begin
			case (cur.phase)
				PH_IDLE: begin
					if (!cur.first_done || since_alert >= {16'd0, interval}) begin
						nxt.phase       = PH_BEEP1;
						nxt.phase_start = now_ms;
					end
				end
				PH_BEEP1: begin
					nxt.buzzer = 1'b1;
					if (elapsed >= {16'd0, cfg.beep_len}) begin
						nxt.buzzer      = 1'b0;
						nxt.phase       = PH_GAP;
						nxt.phase_start = now_ms;
					end
				end
				PH_GAP: begin
					if (elapsed >= {16'd0, cfg.gap_len}) begin
						nxt.phase       = PH_BEEP2;
						nxt.phase_start = now_ms;
					end
				end
				default: begin
					nxt.buzzer = 1'b1;
					if (elapsed >= {16'd0, cfg.beep_len}) begin
						nxt.buzzer     = 1'b0;
						nxt.phase      = PH_IDLE;
						nxt.last_alert = now_ms;
						nxt.first_done = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/escalating_double_beep_alert_top.sv =====
// escalating double-beep alert sequencer, top level; uses edba_pkg, edba_cfg, edba_step
// an input transaction is held in the input register, then its result in the result register
// throughput: one item per cycle while the result channel is not stalled; the sequencer state updates once per item
// reset (arst_n low, asynchronous): idle, buzzer off, times zero, registers to defaults
// in_stall rises only while a result is held and another item is already registered
module escalating_double_beep_alert_top (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 alarm_active,
	input  logic [31:0]          now_ms,
	input  logic [31:0]          alarm_age_ms,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 buzzer_on,
	output logic [1:0]           phase,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  edba_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]          cfg_data
);
	import edba_pkg::*;

	// input register stage
	logic        valid_s1;
	logic        alarm_active_s1;
	logic [31:0] now_ms_s1;
	logic [31:0] alarm_age_ms_s1;

	// sequencer state and result register
	seq_state_t  seq_q;
	seq_state_t  seq_nxt;
	logic        out_valid_q;
	logic        out_buzzer_q;
	phase_code_t out_phase_q;

	cfg_t        cfg;
	logic        in_accept;
	logic        advance;

	// registers can always be written; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	edba_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the registered item moves on when the result register is free or drains now
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			alarm_active_s1 <= alarm_active;
			now_ms_s1       <= now_ms;
			alarm_age_ms_s1 <= alarm_age_ms;
		end
	end

	edba_step u_step (
		.cfg          (cfg),
		.cur          (seq_q),
		.alarm_active (alarm_active_s1),
		.now_ms       (now_ms_s1),
		.alarm_age_ms (alarm_age_ms_s1),
		.nxt          (seq_nxt)
	);

	// state commits once per item, in the cycle the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.phase       <= PH_IDLE;
			seq_q.phase_start <= '0;
			seq_q.last_alert  <= '0;
			seq_q.first_done  <= 1'b0;
			seq_q.buzzer      <= 1'b0;
		end else if (advance) begin
			seq_q <= seq_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload holds while stalled since advance is low then
	always_ff @(posedge clk) begin
		if (advance) begin
			out_buzzer_q <= seq_nxt.buzzer;
			out_phase_q  <= phase_code(seq_nxt.phase);
		end
	end

	assign out_valid = out_valid_q;
	assign buzzer_on = out_buzzer_q;
	assign phase     = out_phase_q;

endmodule

// ===== hw/rtl/edba_checker.sv =====
// port-level checker for the double-beep alert top, attached by bind
// depends on edba_pkg and escalating_double_beep_alert_top_defines.svh
`include "escalating_double_beep_alert_top_defines.svh"

module edba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        buzzer_on,
	input logic [1:0]  phase
);
	import edba_pkg::*;

	// a stalled result transaction keeps its payload
	`EDBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(buzzer_on) && $stable(phase))

	// the buzzer only sounds inside a beep phase
	`EDBA_ASSERT_IMPLY(a_buzz_in_beep, out_valid && buzzer_on, phase == PHASE_CODE_BEEP1 || phase == PHASE_CODE_BEEP2)

	// input backpressure only comes from a held result
	`EDBA_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

bind escalating_double_beep_alert_top edba_checker u_edba_checker (.*);
